// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper.
// Holds the result kind codes, the decoder mode type and the character codes.
// No dependencies.
`default_nettype none

package jsu_pkg;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_END    = 2'd1,
      KIND_NOQ    = 2'd2,
      KIND_UNTERM = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_BODY = 4'b0010,
      MODE_ESC  = 4'b0100,
      MODE_HEX  = 4'b1000
   } mode_type;

   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_BSL   = 8'h5C;
   localparam logic [7:0] CHR_LO_B  = 8'h62;
   localparam logic [7:0] CHR_LO_F  = 8'h66;
   localparam logic [7:0] CHR_LO_N  = 8'h6E;
   localparam logic [7:0] CHR_LO_R  = 8'h72;
   localparam logic [7:0] CHR_LO_T  = 8'h74;
   localparam logic [7:0] CHR_LO_U  = 8'h75;
   localparam logic [7:0] CHR_BS    = 8'h08;
   localparam logic [7:0] CHR_FF    = 8'h0C;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

endpackage

`default_nettype wire

// ===== rtl/jsu_req_if.sv =====
// Input channel of the JSON string unescaper: one character byte per word.
// Depends on nothing.
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/jsu_rsp_if.sv =====
// Result channel of the JSON string unescaper: one decoded byte or marker per word.
// Depends on jsu_pkg for the kind type.
`default_nettype none

interface jsu_rsp_if
   import jsu_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   kind_type   kind;
   logic       last;

   modport source (output valid, output out_byte, output kind, output last, input ready);
   modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/json_string_unescape.sv =====
// Streaming decoder for one JSON string literal, one input byte per word.
// Depends on jsu_pkg, jsu_req_if and jsu_rsp_if.
//
// The req channel carries one character byte per word. The rsp channel gives
// the results that byte causes: decoded data bytes, a string-end marker or an
// error marker, with last set on the final word belonging to that input byte.
// A byte may cause no word at all (blanks before the string, a backslash, the
// first three digits of a \u escape) or up to four words.
// A taken byte sits in the input register, is decoded into the result register
// once that register is free, and its first word is then offered on rsp.
// One byte enters per cycle as long as each byte gives at most one word and the
// receiver takes every word; a byte that gives more words holds the result
// register until its last word is taken, since the result side moves one word a
// cycle. A stalled receiver holds the current word; the input register still takes
// one more byte, then req.ready drops until the result register drains.
// Reset returns the decoder to idle, waiting for an opening quote, and drops
// any byte or word in flight.
`default_nettype none

module json_string_unescape
   import jsu_pkg::*;
(
   input  wire    clock,
   input  wire    reset,
   jsu_req_if.sink   req,
   jsu_rsp_if.source rsp
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [11:0] code_point_ff, code_point_in;
   logic [7:0]  held_ff [3];
   logic [7:0]  held_in [3];

   logic        grp_valid_ff, grp_valid_in;
   logic [7:0]  grp_byte_ff [4];
   kind_type    grp_kind_ff [4];
   logic [1:0]  grp_idx_ff, grp_idx_in;
   logic [1:0]  grp_last_ff;

   logic [7:0]  res_byte [4];
   kind_type    res_kind [4];
   logic [2:0]  res_n;

   logic        grp_end, grp_free, proc;
   logic        body_emit;
   kind_type    body_kind;
   logic [7:0]  body_out;
   mode_type    body_mode;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_full;
   logic [1:0]  slot;
   logic [7:0]  esc_out;

   assign grp_end  = rsp.ready && (grp_idx_ff == grp_last_ff);
   assign grp_free = !grp_valid_ff || grp_end;
   assign proc     = in_valid_ff && grp_free;
   assign req.ready = !in_valid_ff || grp_free;

   assign rsp.valid    = grp_valid_ff;
   assign rsp.out_byte = grp_byte_ff[grp_idx_ff];
   assign rsp.kind     = grp_kind_ff[grp_idx_ff];
   assign rsp.last     = (grp_idx_ff == grp_last_ff);

   always_comb begin
      body_emit = 1'b1;
      body_kind = KIND_DATA;
      body_out  = in_byte_ff;
      body_mode = MODE_BODY;
      if (in_byte_ff == CHR_NUL) begin
         body_kind = KIND_UNTERM;
         body_out  = 8'd0;
         body_mode = MODE_IDLE;
      end else if (in_byte_ff == CHR_QUOTE) begin
         body_kind = KIND_END;
         body_out  = 8'd0;
         body_mode = MODE_IDLE;
      end else if (in_byte_ff == CHR_BSL) begin
         body_emit = 1'b0;
         body_mode = MODE_ESC;
      end
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = in_byte_ff[3:0];
      if (in_byte_ff >= 8'h30 && in_byte_ff <= 8'h39) begin
         hex_val = in_byte_ff[3:0];
      end else if ((in_byte_ff >= 8'h61 && in_byte_ff <= 8'h66) ||
                   (in_byte_ff >= 8'h41 && in_byte_ff <= 8'h46)) begin
         hex_val = 4'(in_byte_ff[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cp_full = {code_point_ff, hex_val};

   always_comb begin
      unique case (in_byte_ff)
         CHR_LO_B: esc_out = CHR_BS;
         CHR_LO_F: esc_out = CHR_FF;
         CHR_LO_N: esc_out = CHR_LF;
         CHR_LO_R: esc_out = CHR_CR;
         CHR_LO_T: esc_out = CHR_TAB;
         default:  esc_out = in_byte_ff;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      held_in       = held_ff;
      res_n         = 3'd0;
      slot          = 2'd0;
      for (int i = 0; i < 4; i++) begin
         res_byte[i] = 8'd0;
         res_kind[i] = KIND_DATA;
      end
      if (proc) begin
         unique case (mode_ff)
            MODE_BODY: begin
               mode_in = body_mode;
               if (body_emit) begin
                  res_byte[0] = body_out;
                  res_kind[0] = body_kind;
                  res_n       = 3'd1;
               end
            end
            MODE_ESC: begin
               if (in_byte_ff == CHR_NUL) begin
                  mode_in     = MODE_IDLE;
                  res_kind[0] = KIND_UNTERM;
                  res_n       = 3'd1;
               end else if (in_byte_ff == CHR_LO_U) begin
                  mode_in       = MODE_HEX;
                  hex_count_in  = 2'd0;
                  code_point_in = 12'd0;
               end else begin
                  mode_in     = MODE_BODY;
                  res_byte[0] = esc_out;
                  res_n       = 3'd1;
               end
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  // Bad digit: the held digits come out as text, then the byte is body.
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < hex_count_ff) begin
                        res_byte[i] = held_ff[i];
                     end
                  end
                  slot          = hex_count_ff;
                  hex_count_in  = 2'd0;
                  code_point_in = 12'd0;
                  mode_in       = body_mode;
                  if (body_emit) begin
                     res_byte[slot] = body_out;
                     res_kind[slot] = body_kind;
                  end
                  res_n = 3'({1'b0, hex_count_ff}) + 3'(body_emit);
               end else if (hex_count_ff != 2'd3) begin
                  held_in[hex_count_ff] = in_byte_ff;
                  hex_count_in          = hex_count_ff + 2'd1;
                  code_point_in         = cp_full[11:0];
               end else begin
                  if (cp_full[15:7] == 9'd0) begin
                     res_byte[0] = cp_full[7:0];
                     res_n       = 3'd1;
                  end else if (cp_full[15:11] == 5'd0) begin
                     res_byte[0] = UTF8_LEAD2 | {3'd0, cp_full[10:6]};
                     res_byte[1] = UTF8_CONT | {2'd0, cp_full[5:0]};
                     res_n       = 3'd2;
                  end else begin
                     res_byte[0] = UTF8_LEAD3 | {4'd0, cp_full[15:12]};
                     res_byte[1] = UTF8_CONT | {2'd0, cp_full[11:6]};
                     res_byte[2] = UTF8_CONT | {2'd0, cp_full[5:0]};
                     res_n       = 3'd3;
                  end
                  hex_count_in  = 2'd0;
                  code_point_in = 12'd0;
                  mode_in       = MODE_BODY;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (in_byte_ff == CHR_QUOTE) begin
                  mode_in = MODE_BODY;
               end else if (in_byte_ff != CHR_SPACE && in_byte_ff != CHR_TAB &&
                            in_byte_ff != CHR_LF && in_byte_ff != CHR_CR) begin
                  res_kind[0] = KIND_NOQ;
                  res_n       = 3'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end

      grp_valid_in = grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      if (grp_valid_ff && rsp.ready) begin
         if (grp_end) begin
            grp_valid_in = 1'b0;
         end else begin
            grp_idx_in = grp_idx_ff + 2'd1;
         end
      end
      if (proc && res_n != 3'd0) begin
         grp_valid_in = 1'b1;
         grp_idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         grp_valid_ff  <= 1'b0;
         grp_idx_ff    <= 2'd0;
         mode_ff       <= MODE_IDLE;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 12'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         grp_valid_ff  <= grp_valid_in;
         grp_idx_ff    <= grp_idx_in;
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.in_byte;
      end
      held_ff <= held_in;
      if (proc && res_n != 3'd0) begin
         grp_byte_ff <= res_byte;
         grp_kind_ff <= res_kind;
         grp_last_ff <= 2'(res_n - 3'd1);
      end
   end

endmodule

`default_nettype wire

// ===== test/tb_json_string_unescape.sv =====
// Testbench for json_string_unescape: directed bytes, then random JSON strings.
// Every result word is checked, against the given word of a directed row or against a predictor kept in this file.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if and the RTL top level.
`default_nettype none

module tb_json_string_unescape;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } word_type;

   typedef struct packed {
      logic [7:0] chr;
      logic       given;
      logic       has_word;
      kind_type   given_kind;
      logic [7:0] given_byte;
   } row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_ITEMS = 460;
   localparam int DRAIN_CYCLES = 20;

   localparam row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'h41,     1'b1, 1'b1, KIND_NOQ,    8'h00},
      '{CHR_NUL,   1'b1, 1'b1, KIND_NOQ,    8'h00},
      '{CHR_SPACE, 1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_TAB,   1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_LF,    1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_CR,    1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_QUOTE, 1'b1, 1'b0, KIND_DATA,   8'h00},
      '{8'hFF,     1'b1, 1'b1, KIND_DATA,   8'hFF},
      '{8'h01,     1'b1, 1'b1, KIND_DATA,   8'h01},
      '{CHR_BSL,   1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_LO_N,  1'b0, 1'b0, KIND_DATA,   8'h00},
      '{CHR_BSL,   1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_LO_U,  1'b1, 1'b0, KIND_DATA,   8'h00},
      '{8'h46,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{8'h66,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{8'h46,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{8'h66,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{CHR_BSL,   1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_LO_U,  1'b1, 1'b0, KIND_DATA,   8'h00},
      '{8'h30,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{8'h37,     1'b0, 1'b0, KIND_DATA,   8'h00},
      '{CHR_QUOTE, 1'b0, 1'b0, KIND_DATA,   8'h00},
      '{CHR_QUOTE, 1'b1, 1'b0, KIND_DATA,   8'h00},
      '{CHR_NUL,   1'b1, 1'b1, KIND_UNTERM, 8'h00}
   };

   localparam logic [7:0] ESCAPE_CHARS [8] = '{
      CHR_QUOTE, CHR_BSL, 8'h2F, CHR_LO_B, CHR_LO_F, CHR_LO_N, CHR_LO_R, CHR_LO_T
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   jsu_req_if req ();
   jsu_rsp_if rsp ();

   json_string_unescape dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always #5 clock = ~clock;

   mode_type    dec_mode;
   logic [1:0]  dec_digits;
   logic [15:0] dec_point;
   logic [7:0]  dec_held [3];
   word_type    step_words [$];
   word_type    pending_words [$];

   row_type     byte_plan [$];
   row_type     cur_row;
   int          next_idx = 0;
   int          accepted_items = 0;
   int          errors = 0;
   int          phase;
   int          send_idle_pct;
   int          stall_pct;
   word_type    want_word;
   word_type    got_word;

   function automatic void emit_word(input logic [7:0] b, input kind_type k);
      word_type w;
      w.out_byte = b;
      w.kind = k;
      w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void body_char(input logic [7:0] c);
      dec_mode = MODE_BODY;
      if (c == CHR_NUL) begin
         dec_mode = MODE_IDLE;
         emit_word(8'h00, KIND_UNTERM);
      end else if (c == CHR_QUOTE) begin
         dec_mode = MODE_IDLE;
         emit_word(8'h00, KIND_END);
      end else if (c == CHR_BSL) begin
         dec_mode = MODE_ESC;
      end else begin
         emit_word(c, KIND_DATA);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] c);
      int          nib;
      logic [15:0] cp;
      logic [7:0]  esc;
      step_words.delete();
      case (dec_mode)
         MODE_BODY: body_char(c);
         MODE_ESC: begin
            dec_mode = MODE_BODY;
            if (c == CHR_NUL) begin
               dec_mode = MODE_IDLE;
               emit_word(8'h00, KIND_UNTERM);
            end else if (c == CHR_LO_U) begin
               dec_mode = MODE_HEX;
               dec_digits = 2'd0;
               dec_point = 16'd0;
            end else begin
               case (c)
                  CHR_LO_B: esc = CHR_BS;
                  CHR_LO_F: esc = CHR_FF;
                  CHR_LO_N: esc = CHR_LF;
                  CHR_LO_R: esc = CHR_CR;
                  CHR_LO_T: esc = CHR_TAB;
                  default:  esc = c;
               endcase
               emit_word(esc, KIND_DATA);
            end
         end
         MODE_HEX: begin
            if (c >= 8'h30 && c <= 8'h39) nib = c - 8'h30;
            else if (c >= 8'h61 && c <= 8'h66) nib = c - 8'h61 + 10;
            else if (c >= 8'h41 && c <= 8'h46) nib = c - 8'h41 + 10;
            else nib = -1;
            if (nib < 0) begin
               for (int i = 0; i < dec_digits; i++) emit_word(dec_held[i], KIND_DATA);
               dec_digits = 2'd0;
               dec_point = 16'd0;
               body_char(c);
            end else begin
               cp = {dec_point[11:0], nib[3:0]};
               if (dec_digits < 2'd3) begin
                  dec_held[dec_digits] = c;
                  dec_digits = dec_digits + 2'd1;
                  dec_point = cp;
               end else begin
                  if (cp < 128) begin
                     emit_word(cp[7:0], KIND_DATA);
                  end else if (cp < 2048) begin
                     emit_word(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_DATA);
                     emit_word(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
                  end else begin
                     emit_word(UTF8_LEAD3 | {4'b0000, cp[15:12]}, KIND_DATA);
                     emit_word(UTF8_CONT | {2'b00, cp[11:6]}, KIND_DATA);
                     emit_word(UTF8_CONT | {2'b00, cp[5:0]}, KIND_DATA);
                  end
                  dec_digits = 2'd0;
                  dec_point = 16'd0;
                  dec_mode = MODE_BODY;
               end
            end
         end
         default: begin
            dec_mode = MODE_IDLE;
            if (c == CHR_SPACE || c == CHR_TAB || c == CHR_LF || c == CHR_CR) begin
            end else if (c == CHR_QUOTE) begin
               dec_mode = MODE_BODY;
            end else begin
               emit_word(8'h00, KIND_NOQ);
            end
         end
      endcase
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
   endfunction

   function automatic void queue_char(input logic [7:0] c);
      row_type r;
      r = '0;
      r.chr = c;
      byte_plan.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         rsp.ready <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            decode_byte(cur_row.chr);
            if (cur_row.given) begin
               if (cur_row.has_word) begin
                  want_word.out_byte = cur_row.given_byte;
                  want_word.kind = cur_row.given_kind;
                  want_word.last = 1'b1;
                  pending_words.push_back(want_word);
               end
            end else begin
               foreach (step_words[i]) pending_words.push_back(step_words[i]);
            end
            accepted_items++;
         end

         if (rsp.valid && rsp.ready) begin
            got_word.out_byte = rsp.out_byte;
            got_word.kind = rsp.kind;
            got_word.last = rsp.last;
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word: byte %h kind %0d last %b",
                        $time, got_word.out_byte, got_word.kind, got_word.last);
               errors++;
            end else begin
               want_word = pending_words.pop_front();
               if (got_word.out_byte !== want_word.out_byte || got_word.kind !== want_word.kind
                   || got_word.last !== want_word.last) begin
                  $display({"%0t: mismatch: expected byte %h kind %0d last %b, ",
                            "got byte %h kind %0d last %b"},
                           $time, want_word.out_byte, want_word.kind, want_word.last,
                           got_word.out_byte, got_word.kind, got_word.last);
                  errors++;
               end
            end
         end

         phase = (accepted_items * 4) / byte_plan.size();
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 65; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase

         if (!req.valid || req.ready) begin
            if (next_idx < byte_plan.size() && $urandom_range(99) >= send_idle_pct) begin
               cur_row = byte_plan[next_idx];
               next_idx++;
               req.valid <= 1'b1;
               req.in_byte <= cur_row.chr;
            end else begin
               req.valid <= 1'b0;
            end
         end
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      int         blank_items;
      int         len;
      int         piece;
      int         digits;
      logic [7:0] c;
      logic [15:0] cp;
      logic [3:0] nib;

      req.valid = 1'b0;
      req.in_byte = 8'h00;
      rsp.ready = 1'b0;
      dec_mode = MODE_IDLE;
      dec_digits = 2'd0;
      dec_point = 16'd0;
      blank_items = 0;

      for (int i = 0; i < DIRECTED_COUNT; i++) byte_plan.push_back(DIRECTED_ROWS[i]);

      while (byte_plan.size() - blank_items - DIRECTED_COUNT < RANDOM_ITEMS) begin
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(3))
               0:       queue_char(CHR_SPACE);
               1:       queue_char(CHR_TAB);
               2:       queue_char(CHR_LF);
               default: queue_char(CHR_CR);
            endcase
            blank_items++;
         end
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(255)));
         end else begin
            queue_char(CHR_QUOTE);
            len = $urandom_range(0, 10);
            repeat (len) begin
               piece = $urandom_range(9);
               case (piece)
                  0, 1, 2, 3: begin
                     do c = 8'($urandom_range(1, 255)); while (c == CHR_QUOTE || c == CHR_BSL);
                     queue_char(c);
                  end
                  4: begin
                     queue_char(CHR_BSL);
                     queue_char(ESCAPE_CHARS[3'($urandom_range(7))]);
                  end
                  5: begin
                     queue_char(CHR_BSL);
                     do c = 8'($urandom_range(1, 255)); while (c == CHR_LO_U);
                     queue_char(c);
                  end
                  6, 7: begin
                     case ($urandom_range(9))
                        0:          cp = 16'h0000;
                        1, 2, 3:    cp = 16'($urandom_range(0, 127));
                        4, 5, 6:    cp = 16'($urandom_range(128, 2047));
                        default:    cp = 16'($urandom_range(2048, 65535));
                     endcase
                     queue_char(CHR_BSL);
                     queue_char(CHR_LO_U);
                     for (int i = 3; i >= 0; i--) begin
                        nib = cp[4*i +: 4];
                        if (nib < 10) queue_char(8'h30 + nib);
                        else if ($urandom_range(1)) queue_char(8'h41 + 8'(nib - 4'd10));
                        else queue_char(8'h61 + 8'(nib - 4'd10));
                     end
                  end
                  8: begin
                     queue_char(CHR_BSL);
                     queue_char(CHR_LO_U);
                     digits = $urandom_range(0, 3);
                     repeat (digits) begin
                        nib = 4'($urandom_range(15));
                        if (nib < 10) queue_char(8'h30 + nib);
                        else if ($urandom_range(1)) queue_char(8'h41 + 8'(nib - 4'd10));
                        else queue_char(8'h61 + 8'(nib - 4'd10));
                     end
                     do c = 8'($urandom_range(255));
                     while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
                            || (c >= 8'h61 && c <= 8'h66));
                     queue_char(c);
                  end
                  default: queue_char(8'($urandom_range(128, 255)));
               endcase
            end
            case ($urandom_range(19))
               0, 1: queue_char(CHR_NUL);
               2: begin
                  queue_char(CHR_BSL);
                  queue_char(CHR_NUL);
               end
               default: queue_char(CHR_QUOTE);
            endcase
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < byte_plan.size() || pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
